### src/prou_pkg.sv
// ----------------------------------------------------------------------------
// prou_pkg
// Shared widths, codes, controller/datapath bundles and the divide-by-255
// helper for the pixel raster operation unit.
// ----------------------------------------------------------------------------
package prou_pkg;

   localparam int DEFAULT_MAX_WIDTH  = 256;
   localparam int DEFAULT_MAX_HEIGHT = 256;
   localparam int DEFAULT_DEPTH_BITS = 24;

   localparam int OPCODE_W    = 2;
   localparam int COORD_W     = 16;
   localparam int CHAN_W      = 8;
   localparam int SRC_DEPTH_W = 24;
   localparam int DIM_W       = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   localparam logic [DIM_W-1:0]  DIM_RESET = 9'd256;
   localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'd255;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_TEST = 2'd2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE = 2'd0,
      OP_BLEND = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOCATE,
      ST_FETCH,
      ST_WRITE,
      ST_PRODUCT,
      ST_MIX,
      ST_RESULT,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic capture;
      logic latch_addr;
      logic fetch;
      logic write_pixel;
      logic product;
      logic mix;
      logic load_rsp;
      logic clear_start;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      op_type opcode;
      logic   in_area;
      logic   alpha_zero;
      logic   area_empty;
      logic   clear_last;
      logic   rsp_free;
   } status_type;

   // floor(v / 255), exact for any v up to 255 * 255
   function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] v);
      logic [2*CHAN_W:0] t;
      t = {1'b0, v} + 17'd1 + {9'd0, v[2*CHAN_W-1:CHAN_W]};
      return t[2*CHAN_W-1:CHAN_W];
   endfunction

endpackage

### src/prou_if.sv
// ----------------------------------------------------------------------------
// prou_req_if / prou_rsp_if
// Valid/ready channels carrying one raster operation and one read result.
// ----------------------------------------------------------------------------
interface prou_req_if;
   import prou_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [OPCODE_W-1:0]       opcode;
   logic signed [COORD_W-1:0] pixel_x;
   logic signed [COORD_W-1:0] pixel_y;
   logic [CHAN_W-1:0]         src_red;
   logic [CHAN_W-1:0]         src_green;
   logic [CHAN_W-1:0]         src_blue;
   logic [CHAN_W-1:0]         src_alpha;
   logic [SRC_DEPTH_W-1:0]    src_depth;

   modport source (
      output valid, opcode, pixel_x, pixel_y, src_red, src_green, src_blue,
             src_alpha, src_depth,
      input  ready
   );

   modport sink (
      input  valid, opcode, pixel_x, pixel_y, src_red, src_green, src_blue,
             src_alpha, src_depth,
      output ready
   );
endinterface

interface prou_rsp_if;
   import prou_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] read_red;
   logic [CHAN_W-1:0] read_green;
   logic [CHAN_W-1:0] read_blue;
   logic [CHAN_W-1:0] read_alpha;

   modport source (
      output valid, read_red, read_green, read_blue, read_alpha,
      input  ready
   );

   modport sink (
      input  valid, read_red, read_green, read_blue, read_alpha,
      output ready
   );
endinterface

### src/prou_ctrl.sv
// ----------------------------------------------------------------------------
// prou_ctrl
// Sequencer: takes one item at a time and steps the datapath through
// locate, store fetch, update or result, and the clear sweep.
// ----------------------------------------------------------------------------
module prou_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  prou_pkg::status_type status,
   output prou_pkg::cmd_type    cmd
);
   import prou_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOCATE;
         end
         ST_LOCATE: begin
            case (status.opcode)
               OP_CLEAR: state_in = status.area_empty ? ST_IDLE : ST_CLEAR;
               OP_READ:  state_in = ST_FETCH;
               OP_WRITE: state_in = status.in_area ? ST_FETCH : ST_IDLE;
               OP_BLEND: state_in = (status.in_area && !status.alpha_zero) ?
                                    ST_FETCH : ST_IDLE;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_FETCH: begin
            case (status.opcode)
               OP_WRITE: state_in = ST_WRITE;
               OP_BLEND: state_in = ST_PRODUCT;
               OP_READ:  state_in = ST_RESULT;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_WRITE:   state_in = ST_IDLE;
         ST_PRODUCT: state_in = ST_MIX;
         ST_MIX:     state_in = ST_IDLE;
         ST_RESULT: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_LOCATE: begin
            cmd.latch_addr  = 1'b1;
            cmd.clear_start = (status.opcode == OP_CLEAR);
         end
         ST_FETCH:   cmd.fetch       = 1'b1;
         ST_WRITE:   cmd.write_pixel = 1'b1;
         ST_PRODUCT: cmd.product     = 1'b1;
         ST_MIX:     cmd.mix         = 1'b1;
         ST_RESULT:  cmd.load_rsp    = status.rsp_free;
         ST_CLEAR:   cmd.clear_step  = 1'b1;
         default: ;
      endcase
   end

   a_capture_to_locate: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == ST_LOCATE)
      else $error("item taken but sequencer did not move to locate");

   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && !status.rsp_free) |=> state_ff == ST_RESULT)
      else $error("read result dropped while output slot was full");

   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && status.clear_last) |=> state_ff == ST_IDLE)
      else $error("clear sweep ran past its last pixel");

endmodule

### src/prou_datapath.sv
// ----------------------------------------------------------------------------
// prou_datapath
// Item and config registers, address calculation, colour and depth stores,
// depth test, blend arithmetic, clear sweep counters and result register.
// ----------------------------------------------------------------------------
module prou_datapath #(
   parameter int MAX_WIDTH  = prou_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = prou_pkg::DEFAULT_MAX_HEIGHT,
   parameter int DEPTH_BITS = prou_pkg::DEFAULT_DEPTH_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  prou_pkg::cmd_type                   cmd,
   output prou_pkg::status_type                status,
   input  logic [prou_pkg::OPCODE_W-1:0]       opcode,
   input  logic signed [prou_pkg::COORD_W-1:0] pixel_x,
   input  logic signed [prou_pkg::COORD_W-1:0] pixel_y,
   input  logic [prou_pkg::CHAN_W-1:0]         src_red,
   input  logic [prou_pkg::CHAN_W-1:0]         src_green,
   input  logic [prou_pkg::CHAN_W-1:0]         src_blue,
   input  logic [prou_pkg::CHAN_W-1:0]         src_alpha,
   input  logic [prou_pkg::SRC_DEPTH_W-1:0]    src_depth,
   input  logic                                csr_write_en,
   input  logic [prou_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [prou_pkg::CSR_DATA_W-1:0]     csr_wdata,
   prou_rsp_if.source                          rsp
);
   import prou_pkg::*;

   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int X_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int Y_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int AW_W   = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
   localparam int AH_W   = ($clog2(MAX_HEIGHT + 1) > DIM_W) ? $clog2(MAX_HEIGHT + 1) : DIM_W;
   localparam int CMP_W  = COORD_W + 1;
   localparam int PIX_W  = 4 * CHAN_W;

   // configuration
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;
   logic             depth_test_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= DIM_RESET;
         height_ff     <= DIM_RESET;
         depth_test_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_WIDTH:      width_ff      <= csr_wdata[DIM_W-1:0];
            CSR_HEIGHT:     height_ff     <= csr_wdata[DIM_W-1:0];
            CSR_DEPTH_TEST: depth_test_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [AW_W-1:0] aw;
   logic [AH_W-1:0] ah;

   // registers above the store size saturate
   assign aw = (AW_W'(width_ff) > AW_W'(MAX_WIDTH)) ? AW_W'(MAX_WIDTH) : AW_W'(width_ff);
   assign ah = (AH_W'(height_ff) > AH_W'(MAX_HEIGHT)) ? AH_W'(MAX_HEIGHT) : AH_W'(height_ff);

   // captured item
   op_type                    opcode_ff;
   logic [COORD_W-1:0]        x_ff;
   logic [COORD_W-1:0]        y_ff;
   logic [CHAN_W-1:0]         src_ff [3];
   logic [CHAN_W-1:0]         alpha_ff;
   logic [DEPTH_BITS-1:0]     depth_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opcode_ff <= op_type'(opcode);
         x_ff      <= pixel_x;
         y_ff      <= pixel_y;
         src_ff[0] <= src_red;
         src_ff[1] <= src_green;
         src_ff[2] <= src_blue;
         alpha_ff  <= src_alpha;
         depth_ff  <= DEPTH_BITS'(src_depth);
      end
   end

   // locate
   logic              inside_in;
   logic [ADDR_W-1:0] addr_in;
   logic              inside_ff;
   logic [ADDR_W-1:0] addr_ff;

   always_comb begin
      inside_in = !x_ff[COORD_W-1] && !y_ff[COORD_W-1] &&
                  ({1'b0, x_ff} < CMP_W'(aw)) && ({1'b0, y_ff} < CMP_W'(ah));
      addr_in   = '0;
      if (inside_in) begin
         addr_in = ADDR_W'(y_ff[Y_W-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_ff[X_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_addr) begin
         inside_ff <= inside_in;
         addr_ff   <= addr_in;
      end
   end

   // clear sweep
   logic [X_W-1:0]    cx_ff;
   logic [Y_W-1:0]    cy_ff;
   logic [ADDR_W-1:0] row_base_ff;
   logic              x_last;
   logic              y_last;

   assign x_last = (AW_W'(cx_ff) + AW_W'(1)) == aw;
   assign y_last = (AH_W'(cy_ff) + AH_W'(1)) == ah;

   always_ff @(posedge clock) begin
      if (cmd.clear_start) begin
         cx_ff       <= '0;
         cy_ff       <= '0;
         row_base_ff <= '0;
      end else if (cmd.clear_step) begin
         if (x_last) begin
            cx_ff       <= '0;
            cy_ff       <= cy_ff + Y_W'(1);
            row_base_ff <= row_base_ff + ADDR_W'(MAX_WIDTH);
         end else begin
            cx_ff <= cx_ff + X_W'(1);
         end
      end
   end

   // stores
   logic [PIX_W-1:0]      color_store_ff [STORE_DEPTH];
   logic [DEPTH_BITS-1:0] depth_store_ff [STORE_DEPTH];
   logic [PIX_W-1:0]      color_rd_ff;
   logic [DEPTH_BITS-1:0] depth_rd_ff;

   logic                  depth_pass;
   logic                  color_we;
   logic                  depth_we;
   logic                  clear_we;
   logic [ADDR_W-1:0]     wr_addr;
   logic [PIX_W-1:0]      color_wdata;
   logic [DEPTH_BITS-1:0] depth_wdata;
   logic [CHAN_W-1:0]     mix_chan [3];

   // products held between the multiply and the divide-by-255 stage
   logic [2*CHAN_W-1:0]   prod_dst_ff [3];
   logic [2*CHAN_W-1:0]   prod_src_ff [3];

   always_ff @(posedge clock) begin
      if (cmd.product) begin
         for (int i = 0; i < 3; i++) begin
            prod_dst_ff[i] <= (2*CHAN_W)'(color_rd_ff[i*CHAN_W +: CHAN_W]) *
                              (2*CHAN_W)'(CHAN_MAX - alpha_ff);
            prod_src_ff[i] <= (2*CHAN_W)'(src_ff[i]) * (2*CHAN_W)'(alpha_ff);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mix_chan[i] = div255(prod_dst_ff[i]) + div255(prod_src_ff[i]);
      end
   end

   // with the depth test on, a stored depth smaller than the new one rejects the write
   assign depth_pass = !(depth_test_ff && (depth_rd_ff < depth_ff));
   assign clear_we   = cmd.clear_step;
   assign depth_we   = (cmd.write_pixel && depth_pass) || clear_we;
   assign color_we   = depth_we || cmd.mix;
   assign wr_addr    = clear_we ? (row_base_ff + ADDR_W'(cx_ff)) : addr_ff;

   always_comb begin
      if (clear_we) begin
         color_wdata = {CHAN_MAX, src_ff[2], src_ff[1], src_ff[0]};
         depth_wdata = '1;
      end else if (cmd.mix) begin
         color_wdata = {color_rd_ff[PIX_W-1 -: CHAN_W], mix_chan[2], mix_chan[1], mix_chan[0]};
         depth_wdata = depth_ff;
      end else begin
         color_wdata = {alpha_ff, src_ff[2], src_ff[1], src_ff[0]};
         depth_wdata = depth_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (color_we) color_store_ff[wr_addr] <= color_wdata;
      if (cmd.fetch) color_rd_ff <= color_store_ff[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (depth_we) depth_store_ff[wr_addr] <= depth_wdata;
      if (cmd.fetch) depth_rd_ff <= depth_store_ff[addr_ff];
   end

   // result register
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_data_ff;
   logic             rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= inside_ff ? color_rd_ff : '0;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.read_red   = rsp_data_ff[0*CHAN_W +: CHAN_W];
   assign rsp.read_green = rsp_data_ff[1*CHAN_W +: CHAN_W];
   assign rsp.read_blue  = rsp_data_ff[2*CHAN_W +: CHAN_W];
   assign rsp.read_alpha = rsp_data_ff[3*CHAN_W +: CHAN_W];

   always_comb begin
      status.opcode     = opcode_ff;
      status.in_area    = inside_in;
      status.alpha_zero = (alpha_ff == '0);
      status.area_empty = (aw == '0) || (ah == '0);
      status.clear_last = x_last && y_last;
      status.rsp_free   = rsp_free;
   end

   a_depth_with_color: assert property (@(posedge clock) disable iff (reset)
      depth_we |-> color_we)
      else $error("depth entry written without its colour entry");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("read result loaded but not presented");

   a_clear_in_area: assert property (@(posedge clock) disable iff (reset)
      clear_we |-> (AW_W'(cx_ff) < aw) && (AH_W'(cy_ff) < ah))
      else $error("clear sweep left the active area");

endmodule

### src/pixel_raster_op_unit.sv
// ----------------------------------------------------------------------------
// pixel_raster_op_unit
// Raster operation unit over per-pixel colour and depth stores: depth-tested
// write, alpha blend, read and area clear.
//
//   channel   dir   handshake            payload
//   req       in    valid / ready        opcode, pixel_x/y, src_rgba, depth
//   rsp       out   valid / ready        read_red/green/blue/alpha
//   csr       in    csr_write_en         csr_index, csr_wdata
//
// One item at a time; all start in locate. Write then fetches and writes,
// read fetches and loads the result, blend fetches, multiplies and mixes;
// a write or blend outside the area, or a blend with alpha zero, ends at
// locate (a read outside returns zero). Clear sweeps one pixel per cycle
// through the single write port. Store reads and writes use separate cycles.
// Reset is synchronous and clears the sequencer, the config and the result
// valid; store contents are not cleared.
// A read result sits in an output register, so later items run while it
// waits; a second read stalls only until that register is free.
// ----------------------------------------------------------------------------
module pixel_raster_op_unit #(
   parameter int MAX_WIDTH  = prou_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = prou_pkg::DEFAULT_MAX_HEIGHT,
   parameter int DEPTH_BITS = prou_pkg::DEFAULT_DEPTH_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   prou_req_if.sink                         req,
   prou_rsp_if.source                       rsp,
   input  logic                             csr_write_en,
   input  logic [prou_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [prou_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import prou_pkg::*;

   cmd_type    cmd;
   status_type status;

   prou_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   prou_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .DEPTH_BITS (DEPTH_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .opcode       (req.opcode),
      .pixel_x      (req.pixel_x),
      .pixel_y      (req.pixel_y),
      .src_red      (req.src_red),
      .src_green    (req.src_green),
      .src_blue     (req.src_blue),
      .src_alpha    (req.src_alpha),
      .src_depth    (req.src_depth),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp          (rsp)
   );

endmodule
